FILE: hw/rtl/bmp_rle_decoder_defines.svh
// assertion macros for the bmp rle decoder checker
// no dependencies; included by files that hold concurrent assertions
`ifndef BMP_RLE_DECODER_DEFINES_SVH
`define BMP_RLE_DECODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BRD_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define BRD_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/brd_pkg.sv
// shared types and constants for the bmp rle decoder
// no dependencies; used by brd_front, brd_back and bmp_rle_decoder
package brd_pkg;

	localparam int unsigned MAX_DIM_DEF       = 4096;
	localparam int unsigned PALETTE_DEPTH_DEF = 256;

	localparam int unsigned CMD_DEPTH = 4;
	localparam int unsigned OUT_DEPTH = 2;

	localparam logic [12:0] X_LIMIT = 13'h1FFF;

	// configuration register indexes
	localparam logic [1:0] REG_RLE_MODE     = 2'd0;
	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

	// input operations
	localparam logic OP_PALETTE = 1'b0;
	localparam logic OP_STREAM  = 1'b1;

	// escape codes following a zero header
	localparam logic [7:0] ESC_EOL   = 8'd0;
	localparam logic [7:0] ESC_EOB   = 8'd1;
	localparam logic [7:0] ESC_DELTA = 8'd2;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_VALUE,
		PH_ESCAPE,
		PH_DELTA_X,
		PH_DELTA_Y,
		PH_ABS,
		PH_PAD
	} phase_t;

	typedef enum logic [1:0] {
		CMD_PAL_WR,
		CMD_SPAN,
		CMD_END
	} cmd_kind_t;

	// command handed from the parser to the palette stage
	typedef struct packed {
		cmd_kind_t   kind;
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  len;
		logic [7:0]  idx_a;
		logic [7:0]  idx_b;
		logic [23:0] rgb;
	} cmd_t;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  len;
		logic [23:0] color_even;
		logic [23:0] color_odd;
		logic        end_flag;
	} result_t;

endpackage

FILE: hw/rtl/brd_ram.sv
// generic ram, one write port, two registered read ports
// no dependencies
module brd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

FILE: hw/rtl/brd_fifo.sv
// small register queue used between parser, palette stage and output
// no dependencies
module brd_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: hw/rtl/brd_front.sv
// stream parser: config registers, cursor, escapes, span clipping
// depends on brd_pkg; emits at most one command per accepted item
module brd_front #(
	parameter int unsigned MAX_DIM = brd_pkg::MAX_DIM_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [12:0]   cfg_data,
	input  logic          in_valid,
	input  logic          operation,
	input  logic [7:0]    stream_byte,
	input  logic [7:0]    palette_slot,
	input  logic [23:0]   palette_rgb,
	output logic          cmd_push,
	output brd_pkg::cmd_t cmd
);

	localparam logic [12:0] X_LIMIT_W = brd_pkg::X_LIMIT;

	logic            mode_q;
	logic [12:0]     width_q;
	logic [12:0]     height_q;
	brd_pkg::phase_t phase_q, nx_phase;
	logic [7:0]      run_q, nx_run;
	logic [7:0]      abs_q, nx_abs;
	logic            pad_q, nx_pad;
	logic [12:0]     cx_q, nx_cx;
	logic [12:0]     cy_q, nx_cy;
	logic            uf_q, nx_uf;
	logic            fin_q, nx_fin;

	logic            span_en;
	logic            add_en;
	logic [7:0]      add_n;
	logic [7:0]      sa;
	logic [7:0]      sb;
	logic            down_en;
	logic [7:0]      dy;
	logic [13:0]     x_sum;
	logic [12:0]     room;
	logic [7:0]      span_len;
	logic [7:0]      abs_dec;
	logic [7:0]      abs_n;
	logic [12:0]     h_new;
	logic            cfg_hit;

	function automatic logic [12:0] clamp_dim(input logic [12:0] v);
		if (32'(v) > MAX_DIM) begin
			clamp_dim = 13'(MAX_DIM);
		end else begin
			clamp_dim = v;
		end
	endfunction

	assign x_sum = 14'(cx_q) + 14'(add_n);
	assign room  = width_q - cx_q;
	assign span_len = (room > 13'(add_n)) ? add_n : room[7:0];
	assign abs_dec  = (abs_q != '0) ? abs_q - 8'd1 : '0;
	assign abs_n    = (run_q >= 8'd2) ? 8'd2 : ((run_q == '0) ? 8'd1 : run_q);

	always_comb begin
		nx_phase = phase_q;
		nx_run   = run_q;
		nx_abs   = abs_q;
		nx_pad   = pad_q;
		nx_cx    = cx_q;
		nx_cy    = cy_q;
		nx_uf    = uf_q;
		nx_fin   = fin_q;
		span_en  = 1'b0;
		add_en   = 1'b0;
		add_n    = '0;
		sa       = stream_byte;
		sb       = stream_byte;
		down_en  = 1'b0;
		dy       = '0;
		cmd_push = 1'b0;
		cmd      = '0;
		cmd.kind = brd_pkg::CMD_SPAN;

		if (in_valid && operation == brd_pkg::OP_PALETTE) begin
			cmd_push  = 1'b1;
			cmd.kind  = brd_pkg::CMD_PAL_WR;
			cmd.idx_a = palette_slot;
			cmd.rgb   = palette_rgb;
		end else if (in_valid && !fin_q) begin
			unique case (phase_q)
				brd_pkg::PH_HEADER: begin
					if (stream_byte != '0) begin
						nx_run   = stream_byte;
						nx_phase = brd_pkg::PH_VALUE;
					end else begin
						nx_phase = brd_pkg::PH_ESCAPE;
					end
				end
				brd_pkg::PH_VALUE: begin
					span_en = 1'b1;
					add_en  = 1'b1;
					add_n   = run_q;
					if (mode_q) begin
						sa = {4'd0, stream_byte[7:4]};
						sb = {4'd0, stream_byte[3:0]};
					end
					nx_run   = '0;
					nx_phase = brd_pkg::PH_HEADER;
				end
				brd_pkg::PH_ESCAPE: begin
					if (stream_byte == brd_pkg::ESC_EOL) begin
						nx_cx    = '0;
						down_en  = 1'b1;
						dy       = 8'd1;
						nx_phase = brd_pkg::PH_HEADER;
					end else if (stream_byte == brd_pkg::ESC_EOB) begin
						cmd_push = 1'b1;
						cmd.kind = brd_pkg::CMD_END;
						cmd.x    = cx_q[11:0];
						cmd.y    = cy_q[11:0];
						nx_fin   = 1'b1;
						nx_phase = brd_pkg::PH_HEADER;
					end else if (stream_byte == brd_pkg::ESC_DELTA) begin
						nx_phase = brd_pkg::PH_DELTA_X;
					end else begin
						nx_run   = stream_byte;
						nx_abs   = mode_q ? 8'((9'(stream_byte) + 9'd1) >> 1) : stream_byte;
						nx_pad   = nx_abs[0];
						nx_phase = brd_pkg::PH_ABS;
					end
				end
				brd_pkg::PH_DELTA_X: begin
					add_en   = 1'b1;
					add_n    = stream_byte;
					nx_phase = brd_pkg::PH_DELTA_Y;
				end
				brd_pkg::PH_DELTA_Y: begin
					down_en  = 1'b1;
					dy       = stream_byte;
					nx_phase = brd_pkg::PH_HEADER;
				end
				brd_pkg::PH_ABS: begin
					span_en = 1'b1;
					add_en  = 1'b1;
					if (mode_q) begin
						add_n = abs_n;
						sa    = {4'd0, stream_byte[7:4]};
						sb    = {4'd0, stream_byte[3:0]};
					end else begin
						add_n = 8'd1;
					end
					nx_run = (run_q >= add_n) ? run_q - add_n : '0;
					nx_abs = abs_dec;
					if (abs_dec == '0) begin
						nx_phase = pad_q ? brd_pkg::PH_PAD : brd_pkg::PH_HEADER;
						nx_pad   = 1'b0;
						nx_run   = '0;
					end
				end
				default: begin
					nx_phase = brd_pkg::PH_HEADER;
				end
			endcase

			// column advance, saturating
			if (add_en) begin
				nx_cx = (x_sum > 14'(X_LIMIT_W)) ? brd_pkg::X_LIMIT : x_sum[12:0];
			end

			// row move toward the top, latching underflow
			if (down_en && !uf_q) begin
				if (13'(dy) > cy_q) begin
					nx_uf = 1'b1;
					nx_cy = '0;
				end else begin
					nx_cy = cy_q - 13'(dy);
				end
			end

			// clipped span, dropped when empty, starting past the right edge or beyond the top row
			if (span_en && !uf_q && cx_q < width_q && add_n != '0) begin
				cmd_push  = 1'b1;
				cmd.kind  = brd_pkg::CMD_SPAN;
				cmd.x     = cx_q[11:0];
				cmd.y     = cy_q[11:0];
				cmd.len   = span_len;
				cmd.idx_a = sa;
				cmd.idx_b = (span_len == 8'd1) ? sa : sb;
			end
		end
	end

	assign cfg_hit = cfg_we && (cfg_index == brd_pkg::REG_RLE_MODE ||
		cfg_index == brd_pkg::REG_IMAGE_WIDTH || cfg_index == brd_pkg::REG_IMAGE_HEIGHT);
	assign h_new = (cfg_index == brd_pkg::REG_IMAGE_HEIGHT) ? clamp_dim(cfg_data) : height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 1'b0;
			width_q  <= 13'd1;
			height_q <= 13'd1;
			phase_q  <= brd_pkg::PH_HEADER;
			run_q    <= '0;
			abs_q    <= '0;
			pad_q    <= 1'b0;
			cx_q     <= '0;
			cy_q     <= '0;
			uf_q     <= 1'b0;
			fin_q    <= 1'b0;
		end else if (cfg_hit) begin
			if (cfg_index == brd_pkg::REG_RLE_MODE) begin
				mode_q <= cfg_data[0];
			end
			if (cfg_index == brd_pkg::REG_IMAGE_WIDTH) begin
				width_q <= clamp_dim(cfg_data);
			end
			height_q <= h_new;
			phase_q  <= brd_pkg::PH_HEADER;
			run_q    <= '0;
			abs_q    <= '0;
			pad_q    <= 1'b0;
			cx_q     <= '0;
			fin_q    <= 1'b0;
			cy_q     <= (h_new == '0) ? '0 : h_new - 13'd1;
			uf_q     <= (h_new == '0);
		end else begin
			phase_q <= nx_phase;
			run_q   <= nx_run;
			abs_q   <= nx_abs;
			pad_q   <= nx_pad;
			cx_q    <= nx_cx;
			cy_q    <= nx_cy;
			uf_q    <= nx_uf;
			fin_q   <= nx_fin;
		end
	end

endmodule

FILE: hw/rtl/brd_back.sv
// palette stage: applies palette writes, looks up span colours
// depends on brd_pkg and brd_ram; one registered lookup stage
module brd_back #(
	parameter int PALETTE_DEPTH = brd_pkg::PALETTE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  brd_pkg::cmd_t    cmd,
	input  logic             cmd_empty,
	output logic             cmd_pop,
	output logic             res_push,
	output brd_pkg::result_t res,
	input  logic             res_full
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic        head_wr;
	logic        s1_free;
	logic        a_ok;
	logic        b_ok;
	logic        ram_we;
	logic        ram_re;
	logic [23:0] rd_a;
	logic [23:0] rd_b;

	logic        valid_s1;
	logic [11:0] x_s1;
	logic [11:0] y_s1;
	logic [7:0]  len_s1;
	logic        end_s1;
	logic        zero_a_s1;
	logic        zero_b_s1;

	assign head_wr = (cmd.kind == brd_pkg::CMD_PAL_WR);
	assign s1_free = !valid_s1 || !res_full;
	assign cmd_pop = !cmd_empty && (head_wr || s1_free);
	// entries beyond the palette ignore writes and read as zero
	assign a_ok    = ({1'b0, cmd.idx_a} < 9'(PALETTE_DEPTH));
	assign b_ok    = ({1'b0, cmd.idx_b} < 9'(PALETTE_DEPTH));
	assign ram_we  = cmd_pop && head_wr && a_ok;
	assign ram_re  = cmd_pop && !head_wr;

	brd_ram #(
		.WIDTH(24),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (cmd.idx_a[AW-1:0]),
		.wdata   (cmd.rgb),
		.re      (ram_re),
		.raddr_a (cmd.idx_a[AW-1:0]),
		.raddr_b (cmd.idx_b[AW-1:0]),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= ram_re;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && ram_re) begin
			x_s1      <= cmd.x;
			y_s1      <= cmd.y;
			len_s1    <= cmd.len;
			end_s1    <= (cmd.kind != brd_pkg::CMD_SPAN);
			zero_a_s1 <= (cmd.kind != brd_pkg::CMD_SPAN) || !a_ok;
			zero_b_s1 <= (cmd.kind != brd_pkg::CMD_SPAN) || !b_ok;
		end
	end

	assign res_push       = valid_s1 && !res_full;
	assign res.x          = x_s1;
	assign res.y          = y_s1;
	assign res.len        = len_s1;
	assign res.color_even = zero_a_s1 ? '0 : rd_a;
	assign res.color_odd  = zero_b_s1 ? '0 : rd_b;
	assign res.end_flag   = end_s1;

endmodule

FILE: hw/rtl/bmp_rle_decoder.sv
// top level of the bmp rle8/rle4 span decoder
// depends on brd_pkg, brd_front, brd_fifo, brd_back (brd_ram below it)
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------------
//  input     push / full               operation, stream_byte, palette_slot,
//                                      palette_rgb
//  result    empty / pop               span_x, span_y, span_length, color_even,
//                                      color_odd, end_of_image
//  config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// one request per cycle in and out unless full or empty; the parser settles a byte
// in the cycle it is accepted, so the rate is one item per clock, bounded by the
// palette stage; spans pass the command queue, lookup stage and result queue
// arst_n clears all control state; palette contents stay undefined until written
// full rises once four commands wait for the palette stage; the result side holds
// two entries, so a stalled pop backs up through the palette stage into full
module bmp_rle_decoder #(
	parameter int unsigned MAX_DIM       = brd_pkg::MAX_DIM_DEF,
	parameter int          PALETTE_DEPTH = brd_pkg::PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [7:0]  stream_byte,
	input  logic [7:0]  palette_slot,
	input  logic [23:0] palette_rgb,
	// result requests
	output logic        empty,
	input  logic        pop,
	output logic [11:0] span_x,
	output logic [11:0] span_y,
	output logic [7:0]  span_length,
	output logic [23:0] color_even,
	output logic [23:0] color_odd,
	output logic        end_of_image,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	brd_pkg::cmd_t    cmd_in;
	brd_pkg::cmd_t    cmd_head;
	brd_pkg::result_t res_in;
	brd_pkg::result_t res_head;

	logic [$bits(brd_pkg::cmd_t)-1:0]    cmd_head_bits;
	logic [$bits(brd_pkg::result_t)-1:0] res_head_bits;

	logic accept;
	logic cmd_push;
	logic cmd_empty;
	logic cmd_pop;
	logic res_push;
	logic res_full;

	// config writes always taken; users land them only while idle; block never checks
	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	// parser: one stream byte or palette write per accepted request
	brd_front #(
		.MAX_DIM(MAX_DIM)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (accept),
		.operation    (operation),
		.stream_byte  (stream_byte),
		.palette_slot (palette_slot),
		.palette_rgb  (palette_rgb),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	// command queue decouples parsing from palette access
	brd_fifo #(
		.WIDTH($bits(brd_pkg::cmd_t)),
		.DEPTH(brd_pkg::CMD_DEPTH)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_in),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_head_bits),
		.empty  (cmd_empty)
	);

	assign cmd_head = brd_pkg::cmd_t'(cmd_head_bits);

	// palette writes and colour lookups, in stream order
	brd_back #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_head),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res       (res_in),
		.res_full  (res_full)
	);

	// result queue, also the output register
	brd_fifo #(
		.WIDTH($bits(brd_pkg::result_t)),
		.DEPTH(brd_pkg::OUT_DEPTH)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_in),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head_bits),
		.empty  (empty)
	);

	assign res_head     = brd_pkg::result_t'(res_head_bits);
	assign span_x       = res_head.x;
	assign span_y       = res_head.y;
	assign span_length  = res_head.len;
	assign color_even   = res_head.color_even;
	assign color_odd    = res_head.color_odd;
	assign end_of_image = res_head.end_flag;

endmodule

FILE: hw/rtl/brd_checker.sv
// port-level checks on the result side of the decoder, bound to the top level
// depends on bmp_rle_decoder_defines.svh
`include "bmp_rle_decoder_defines.svh"

module brd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [11:0] span_x,
	input logic [11:0] span_y,
	input logic [7:0]  span_length,
	input logic [23:0] color_even,
	input logic [23:0] color_odd,
	input logic        end_of_image
);

	// end marker carries no pixels and no colours
	`BRD_ASSERT_NOW(a_end_blank, clk, arst_n, !empty && end_of_image, span_length == 8'd0 && color_even == 24'd0 && color_odd == 24'd0, "end item carries pixel data")

	// a span is never empty
	`BRD_ASSERT_NOW(a_span_len, clk, arst_n, !empty && !end_of_image, span_length != 8'd0, "span with zero length")

	// single pixel spans repeat the even colour
	`BRD_ASSERT_NOW(a_one_pixel, clk, arst_n, !empty && span_length == 8'd1, color_odd == color_even, "one pixel span with two colours")

	// a waiting result holds until taken
	`BRD_ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(span_x) && $stable(span_y) && $stable(span_length) && $stable(color_even) && $stable(color_odd) && $stable(end_of_image), "waiting result changed")

endmodule

bind bmp_rle_decoder brd_checker u_brd_checker (.*);
